// ===== design/pcs_pkg.sv =====
// Shared types and constants for the streaming Pearson correlation block.
// No dependencies; every design file except pcs_if imports this package.
`default_nettype none
package pcs_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_PAIRS   = 65536;
  localparam int COUNT_BITS  = 17;
  localparam int SUM_BITS    = 33;
  localparam int SQ_BITS     = 47;
  localparam int XP_BITS     = 48;
  localparam int WORD_BITS   = 64;
  localparam int MUL_A_BITS  = 128;
  localparam int MUL_B_BITS  = 64;
  localparam int MUL_P_BITS  = MUL_A_BITS + MUL_B_BITS;
  localparam int LHS_BITS    = 160;
  localparam int COEF_BITS   = 16;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OUT_VALID = 2'd0,
    OUT_FEW   = 2'd1,
    OUT_FLAT  = 2'd2
  } outcome_t;

  typedef struct packed {
    logic        [COUNT_BITS-1:0] n;
    logic signed [SUM_BITS-1:0]   sx;
    logic signed [SUM_BITS-1:0]   sy;
    logic        [SQ_BITS-1:0]    sxx;
    logic        [SQ_BITS-1:0]    syy;
    logic signed [XP_BITS-1:0]    sxy;
  } sums_t;

  typedef struct packed {
    logic                  start;
    logic [MUL_A_BITS-1:0] a;
    logic [MUL_B_BITS-1:0] b;
  } mul_req_t;

endpackage
`default_nettype wire

// ===== design/pcs_if.sv =====
// Valid/ready channels for sample pairs and correlation results.
// Depends on nothing.
`default_nettype none
interface pcs_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_sample;
  logic signed [15:0] y_sample;
  logic               last_pair;
  modport source(output valid, x_sample, y_sample, last_pair, input ready);
  modport sink(input valid, x_sample, y_sample, last_pair, output ready);
endinterface

interface pcs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] coefficient;
  logic [1:0]         outcome;
  logic [16:0]        pair_count;
  modport source(output valid, coefficient, outcome, pair_count, input ready);
  modport sink(input valid, coefficient, outcome, pair_count, output ready);
endinterface
`default_nettype wire

// ===== design/pcs_queue.sv =====
// Small FIFO of finished sum snapshots between front and back.
// Depends on pcs_pkg.
`default_nettype none
module pcs_queue #(
  parameter int DEPTH = 2
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  pcs_pkg::sums_t   push_data,
  output logic             full,
  input  wire              pop,
  output pcs_pkg::sums_t   pop_data,
  output logic             not_empty
);
  import pcs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sums_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/pcs_front.sv =====
// Front end: accepts sample pairs and keeps the running count and sums.
// On a last pair it pushes the finished sums to the queue. Depends on pcs_pkg, pcs_if.
`default_nettype none
module pcs_front (
  input  wire             clk,
  input  wire             rst,
  pcs_in_if.sink          samples,
  output logic            push,
  output pcs_pkg::sums_t  push_data,
  input  wire             full
);
  import pcs_pkg::*;

  sums_t              acc;
  sums_t              acc_next;
  logic               accept;
  logic signed [31:0] pxx;
  logic signed [31:0] pyy;
  logic signed [31:0] pxy;

  assign samples.ready = !full;
  assign accept        = samples.valid && samples.ready;
  assign pxx           = samples.x_sample * samples.x_sample;
  assign pyy           = samples.y_sample * samples.y_sample;
  assign pxy           = samples.x_sample * samples.y_sample;

  always_comb begin
    acc_next = acc;
    if (acc.n < COUNT_BITS'(MAX_PAIRS)) begin
      acc_next.n   = acc.n + 1'b1;
      acc_next.sx  = acc.sx + {{(SUM_BITS-16){samples.x_sample[15]}}, samples.x_sample};
      acc_next.sy  = acc.sy + {{(SUM_BITS-16){samples.y_sample[15]}}, samples.y_sample};
      acc_next.sxx = acc.sxx + {{(SQ_BITS-32){1'b0}}, pxx};
      acc_next.syy = acc.syy + {{(SQ_BITS-32){1'b0}}, pyy};
      acc_next.sxy = acc.sxy + {{(XP_BITS-32){pxy[31]}}, pxy};
    end
  end

  assign push      = accept && samples.last_pair;
  assign push_data = acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (accept) begin
      acc <= samples.last_pair ? '0 : acc_next;
    end
  end
endmodule
`default_nettype wire

// ===== design/pcs_mul.sv =====
// Shift-add multiplier, 128 x 64 bits, one multiplier bit per cycle.
// Depends on pcs_pkg.
`default_nettype none
module pcs_mul (
  input  wire                              clk,
  input  wire                              rst,
  input  pcs_pkg::mul_req_t                req,
  output logic                             done,
  output logic [pcs_pkg::MUL_P_BITS-1:0]   product
);
  import pcs_pkg::*;

  localparam int CNT_BITS = $clog2(MUL_B_BITS);

  logic                    busy;
  logic [CNT_BITS-1:0]     cnt;
  logic [MUL_A_BITS-1:0]   a_reg;
  logic [MUL_P_BITS:0]     prod;
  logic [MUL_A_BITS:0]     upper;

  assign upper   = prod[MUL_P_BITS:MUL_B_BITS]
                 + (prod[0] ? {1'b0, a_reg} : {(MUL_A_BITS+1){1'b0}});
  assign product = prod[MUL_P_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        a_reg <= req.a;
        prod  <= {{(MUL_A_BITS+1){1'b0}}, req.b};
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        prod <= {1'b0, upper, prod[MUL_B_BITS-1:1]};
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_BITS'(MUL_B_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/pcs_back.sv =====
// Back end: takes a sum snapshot, forms covariance and variances, then
// searches the rounded coefficient bit-exactly. Depends on pcs_pkg, pcs_if, pcs_mul.
`default_nettype none
module pcs_back (
  input  wire              clk,
  input  wire              rst,
  input  wire              not_empty,
  input  pcs_pkg::sums_t   pop_data,
  output logic             pop,
  pcs_out_if.source        results
);
  import pcs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_GO, S_MUL_WAIT, S_PICK, S_SQ_GO, S_SQ_WAIT, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_NSXY, OP_SXSY, OP_NSXX, OP_SXSX, OP_NSYY, OP_SYSY, OP_MAG, OP_DEN
  } op_t;

  state_t                  state;
  op_t                     op;
  sums_t                   snap;
  logic [WORD_BITS-1:0]    num;
  logic [WORD_BITS-1:0]    vx;
  logic [WORD_BITS-1:0]    vy;
  logic [WORD_BITS-1:0]    mag;
  logic                    neg;
  logic [LHS_BITS-1:0]     lhs;
  logic [MUL_A_BITS-1:0]   den;
  logic [15:0]             lo;
  logic [15:0]             hi;
  logic [15:0]             mid;
  logic [31:0]             odd2;
  logic [16:0]             mid_sum;
  logic [15:0]             mid_w;
  logic [15:0]             odd_w;
  logic [WORD_BITS-1:0]    p64;
  logic [WORD_BITS-1:0]    vy_w;
  logic [WORD_BITS-1:0]    n64, sx64, sy64, sxx64, syy64, sxy64;
  logic [WORD_BITS-1:0]    opa;
  logic [WORD_BITS-1:0]    opb;
  mul_req_t                req;
  logic                    mul_done;
  logic [MUL_P_BITS-1:0]   product;
  logic                    valid_q;
  logic signed [15:0]      coef_q;
  outcome_t                outcome_q;
  logic [COUNT_BITS-1:0]   count_q;

  pcs_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .done    (mul_done),
    .product (product)
  );

  assign n64   = {{(WORD_BITS-COUNT_BITS){1'b0}}, snap.n};
  assign sx64  = {{(WORD_BITS-SUM_BITS){snap.sx[SUM_BITS-1]}}, snap.sx};
  assign sy64  = {{(WORD_BITS-SUM_BITS){snap.sy[SUM_BITS-1]}}, snap.sy};
  assign sxx64 = {{(WORD_BITS-SQ_BITS){1'b0}}, snap.sxx};
  assign syy64 = {{(WORD_BITS-SQ_BITS){1'b0}}, snap.syy};
  assign sxy64 = {{(WORD_BITS-XP_BITS){snap.sxy[XP_BITS-1]}}, snap.sxy};

  always_comb begin
    case (op)
      OP_NSXY: begin opa = n64;  opb = sxy64; end
      OP_SXSY: begin opa = sx64; opb = sy64;  end
      OP_NSXX: begin opa = n64;  opb = sxx64; end
      OP_SXSX: begin opa = sx64; opb = sx64;  end
      OP_NSYY: begin opa = n64;  opb = syy64; end
      OP_SYSY: begin opa = sy64; opb = sy64;  end
      OP_MAG:  begin opa = mag;  opb = mag;   end
      OP_DEN:  begin opa = vx;   opb = vy;    end
      default: begin opa = '0;   opb = '0;    end
    endcase
  end

  always_comb begin
    req.start = (state == S_MUL_GO) || (state == S_SQ_GO);
    if (state == S_SQ_GO) begin
      req.a = den;
      req.b = {{(MUL_B_BITS-32){1'b0}}, odd2};
    end else begin
      req.a = {{(MUL_A_BITS-WORD_BITS){1'b0}}, opa};
      req.b = opb;
    end
  end

  assign pop     = (state == S_IDLE) && not_empty;
  assign p64     = product[WORD_BITS-1:0];
  assign vy_w    = vy - p64;
  assign mid_sum = {1'b0, lo} + {1'b0, hi} + 17'd1;
  assign mid_w   = mid_sum[16:1];
  assign odd_w   = {mid_w[14:0], 1'b0} - 16'd1;

  assign results.valid       = valid_q;
  assign results.coefficient = coef_q;
  assign results.outcome     = outcome_q;
  assign results.pair_count  = count_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      valid_q <= 1'b0;
      op      <= OP_NSXY;
    end else begin
      case (state)
        S_IDLE: begin
          if (not_empty) begin
            snap    <= pop_data;
            count_q <= pop_data.n;
            op      <= OP_NSXY;
            if (pop_data.n < COUNT_BITS'(2)) begin
              coef_q    <= '0;
              outcome_q <= OUT_FEW;
              valid_q   <= 1'b1;
              state     <= S_OUT;
            end else begin
              state <= S_MUL_GO;
            end
          end
        end
        S_MUL_GO: state <= S_MUL_WAIT;
        S_MUL_WAIT: begin
          if (mul_done) begin
            op <= op_t'(op + 3'd1);
            case (op)
              OP_NSXY: begin num <= p64;       state <= S_MUL_GO; end
              OP_SXSY: begin num <= num - p64; state <= S_MUL_GO; end
              OP_NSXX: begin vx  <= p64;       state <= S_MUL_GO; end
              OP_SXSX: begin vx  <= vx - p64;  state <= S_MUL_GO; end
              OP_NSYY: begin vy  <= p64;       state <= S_MUL_GO; end
              OP_SYSY: begin
                vy  <= vy_w;
                neg <= num[WORD_BITS-1];
                mag <= num[WORD_BITS-1] ? (WORD_BITS'(0) - num) : num;
                if (vx == '0 || vy_w == '0) begin
                  coef_q    <= '0;
                  outcome_q <= OUT_FLAT;
                  valid_q   <= 1'b1;
                  state     <= S_OUT;
                end else begin
                  state <= S_MUL_GO;
                end
              end
              OP_MAG: begin
                lhs   <= {product[LHS_BITS-33:0], 32'd0};
                state <= S_MUL_GO;
              end
              OP_DEN: begin
                den   <= product[MUL_A_BITS-1:0];
                lo    <= '0;
                hi    <= 16'd32768;
                state <= S_PICK;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_PICK: begin
          if (lo < hi) begin
            mid   <= mid_w;
            odd2  <= odd_w * odd_w;
            state <= S_SQ_GO;
          end else begin
            if (neg) begin
              coef_q <= 16'd0 - lo;
            end else begin
              coef_q <= (lo > 16'd32767) ? 16'sd32767 : lo;
            end
            outcome_q <= OUT_VALID;
            valid_q   <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_SQ_GO: state <= S_SQ_WAIT;
        S_SQ_WAIT: begin
          if (mul_done) begin
            if ({{(MUL_P_BITS-LHS_BITS){1'b0}}, lhs} >= product) begin
              lo <= mid;
            end else begin
              hi <= mid - 16'd1;
            end
            state <= S_PICK;
          end
        end
        S_OUT: begin
          if (results.ready) begin
            valid_q <= 1'b0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/pearson_correlation_stream.sv =====
// Streaming Pearson correlation: sample pairs in, one Q1.15 coefficient per series.
// Depends on pcs_pkg, pcs_if, pcs_queue, pcs_front, pcs_back.
//
// Usage:
//   samples: valid/ready channel of (x_sample, y_sample, last_pair). One pair
//   is taken per cycle while the snapshot queue has room; last_pair closes
//   the series and hands its sums to the back end.
//   results: valid/ready channel of (coefficient, outcome, pair_count), one
//   word per series.
// A short series (fewer than two pairs) is reported without a multiply; a zero
//   variance is reported after six setup products; a full result takes eight
//   setup products on the shift-add multiplier and one more per search step.
// Throughput: one pair per cycle while the queue has room; the back end takes
//   a new series only after the result word of the last one is accepted.
// Up to QUEUE_DEPTH finished series wait in the queue, so the front keeps
//   taking pairs while the back end computes or the receiver stalls.
// A stalled receiver holds the result word; ready drops only when the
//   queue is full. Reset clears the sums, the queue and the sequencer.
`default_nettype none
module pearson_correlation_stream #(
  parameter int QUEUE_DEPTH = pcs_pkg::QUEUE_DEPTH
) (
  input  wire        clk,
  input  wire        rst,
  pcs_in_if.sink     samples,
  pcs_out_if.source  results
);
  import pcs_pkg::*;

  logic  push;
  logic  full;
  logic  pop;
  logic  not_empty;
  sums_t push_data;
  sums_t pop_data;

  pcs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  pcs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (not_empty)
  );

  pcs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .pop_data  (pop_data),
    .pop       (pop),
    .results   (results)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("snapshot pushed into full queue");
  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.outcome == OUT_VALID) |-> (results.pair_count >= 17'd2))
    else $error("coefficient reported for fewer than two pairs");
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.outcome != OUT_VALID) |-> (results.coefficient == 16'sd0))
    else $error("nonzero coefficient with fault outcome");
`endif
endmodule
`default_nettype wire
